// ----- rtl/edf_pkg.sv -----
// Shared types, constants and helpers for the EDF task scheduler.
// No dependencies; used by edf_cell and edf_task_scheduler.
package edf_pkg;

  // Task table geometry
  localparam int TASK_SLOTS = 16;
  localparam int IDX_W      = $clog2(TASK_SLOTS);
  localparam int TICK_W     = 32;
  localparam int SLOT_W     = 4;

  localparam logic [TICK_W-1:0] IDLE_DEADLINE = '1;

  // Request kinds
  typedef enum logic [2:0] {
    KIND_CREATE    = 3'd0,
    KIND_TERMINATE = 3'd1,
    KIND_SLEEP     = 3'd2,
    KIND_SET_DL    = 3'd3,
    KIND_TICK      = 3'd4,
    KIND_SET_TICKS = 3'd5
  } kind_t;

  // Control FSM states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Operation broadcast to every cell for the duration of a scan
  typedef struct packed {
    logic [2:0]        kind;
    logic [TICK_W-1:0] value;
    logic [TICK_W-1:0] wake;    // tick_count + value, for sleep
    logic [TICK_W-1:0] tick;    // tick count after this request
    logic [IDX_W-1:0]  cur;     // running slot before this request
    logic              cur_ok;  // running slot is not the idle task
  } op_t;

  // Token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              claimed;   // a free slot was taken by create
    logic [IDX_W-1:0]  created;
    logic              found;     // a ready slot has been seen
    logic [TICK_W-1:0] best_dl;
    logic [IDX_W-1:0]  best_idx;
  } carry_t;

  // Slot index reported on the 4-bit result ports (low bits)
  function automatic logic [SLOT_W-1:0] slot_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

// ----- rtl/edf_task_scheduler.sv -----
// Top level of the EDF task scheduler: request capture, control FSM and
// the chain of TASK_SLOTS slot cells. Depends on edf_pkg and edf_cell.
//
//  channel   | handshake           | ports
//  ----------+---------------------+--------------------------------------------
//  request   | start & !busy       | kind, value
//  result    | done (one cycle)    | running_task, new_task, status, current_tick
//
// Each request passes through a launch cycle, then a scan in which the token walks
// the chain through the registered cell stages, and then the result cycle.
// A new request may be accepted during the result cycle.
// Reset (rst, synchronous) leaves only the idle task in slot 0, tick zero.
// Results cannot be stalled; done is high for exactly one cycle per request.
module edf_task_scheduler
  import edf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        kind,
  input  logic [TICK_W-1:0] value,
  output logic              done,
  output logic [SLOT_W-1:0] running_task,
  output logic [SLOT_W-1:0] new_task,
  output logic              status,
  output logic [TICK_W-1:0] current_tick
);

  state_t state;
  state_t state_next;

  logic              accept;
  logic [2:0]        kind_r;
  logic [TICK_W-1:0] value_r;
  logic [TICK_W-1:0] wake_r;
  logic [TICK_W-1:0] tick_count;
  logic [IDX_W-1:0]  current_running;

  op_t    op;
  carry_t chain [TASK_SLOTS+1];
  carry_t last;

  assign accept = start && !busy;
  assign last   = chain[TASK_SLOTS];

  // Control FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        busy       = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        busy = 1'b1;
        if (last.valid) state_next = ST_DONE;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = start ? ST_LAUNCH : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Tick counter and running-slot register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      current_running <= '0;
    end else begin
      if (accept) begin
        case (kind_t'(kind))
          KIND_TICK:      tick_count <= tick_count + TICK_W'(1);
          KIND_SET_TICKS: tick_count <= value;
          default: ;
        endcase
      end
      if (state == ST_SCAN && last.valid) begin
        current_running <= last.best_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind;
      value_r <= value;
      wake_r  <= tick_count + value;
    end
  end

  // Operation seen by every cell during the scan
  always_comb begin
    op.kind   = kind_r;
    op.value  = value_r;
    op.wake   = wake_r;
    op.tick   = tick_count;
    op.cur    = current_running;
    op.cur_ok = (current_running != '0);
  end

  // Token injected into the head of the chain
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = (state == ST_LAUNCH);
  end

  // Row of slot cells
  for (genvar k = 0; k < TASK_SLOTS; k++) begin : g_cell
    edf_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .idx  (IDX_W'(k)),
      .op   (op),
      .cin  (chain[k]),
      .cout (chain[k+1])
    );
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && last.valid) begin
      running_task <= slot_out(last.best_idx);
      current_tick <= tick_count;
      new_task     <= '0;
      status       <= 1'b0;
      case (kind_t'(kind_r))
        KIND_CREATE: begin
          if (last.claimed) new_task <= slot_out(last.created);
          else              status   <= 1'b1;
        end
        KIND_TERMINATE, KIND_SLEEP, KIND_SET_DL: begin
          status <= !op.cur_ok;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/edf_cell.sv -----
// One task slot of the scheduler chain: slot state plus one token stage.
// Depends on edf_pkg.
module edf_cell
  import edf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  op_t              op,
  input  carry_t           cin,
  output carry_t           cout
);

  logic              used;
  logic              sleeping;
  logic [TICK_W-1:0] deadline;
  logic [TICK_W-1:0] wake;

  logic              used_next;
  logic              sleeping_next;
  logic [TICK_W-1:0] deadline_next;
  logic [TICK_W-1:0] wake_next;
  carry_t            cout_next;

  logic is_idle;
  logic hit;
  logic ready;

  assign is_idle = (idx == '0);
  assign hit     = op.cur_ok && (idx == op.cur);

  // Apply the request to this slot, then compete for earliest deadline
  always_comb begin
    used_next     = used;
    sleeping_next = sleeping;
    deadline_next = deadline;
    wake_next     = wake;
    cout_next     = cin;

    case (op.kind)
      KIND_CREATE: begin
        if (!used && !is_idle && !cin.claimed) begin
          used_next         = 1'b1;
          sleeping_next     = 1'b0;
          deadline_next     = op.value;
          cout_next.claimed = 1'b1;
          cout_next.created = idx;
        end
      end
      KIND_TERMINATE: begin
        if (hit) begin
          used_next     = 1'b0;
          sleeping_next = 1'b0;
        end
      end
      KIND_SLEEP: begin
        if (hit) begin
          wake_next     = op.wake;
          sleeping_next = 1'b1;
        end
      end
      KIND_SET_DL: begin
        if (hit) begin
          deadline_next = op.value;
        end
      end
      KIND_TICK: begin
        if (used && sleeping && ((wake == op.tick) || (deadline < op.tick))) begin
          sleeping_next = 1'b0;
        end
      end
      default: ;
    endcase

    // Strict less-than keeps ties on the lower slot
    ready = used_next && !sleeping_next;
    if (ready && (!cin.found || (deadline_next < cin.best_dl))) begin
      cout_next.found    = 1'b1;
      cout_next.best_dl  = deadline_next;
      cout_next.best_idx = idx;
    end
  end

  // Slot state updates only while the token passes through
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= is_idle;
      sleeping <= 1'b0;
      deadline <= IDLE_DEADLINE;
      cout     <= '0;
    end else begin
      cout <= cout_next;
      if (cin.valid) begin
        used     <= used_next;
        sleeping <= sleeping_next;
        deadline <= deadline_next;
        wake     <= wake_next;
      end
    end
  end

endmodule

// ----- sim/tb_edf_task_scheduler.sv -----
// Self-checking testbench for edf_task_scheduler: a directed request table, then random
// requests checked against an in-bench EDF scheduling predictor.
// Depends on rtl/edf_pkg.sv and rtl/edf_task_scheduler.sv.
`timescale 1ns / 100ps

module tb_edf_task_scheduler;
  import edf_pkg::*;

  // Kinds the block ignores, and result status codes
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam logic       STATUS_OK    = 1'b0;
  localparam logic       STATUS_FAIL  = 1'b1;

  localparam int RANDOM_REQUESTS = 1050;
  localparam int DRAIN_CYCLES    = 2 * TASK_SLOTS + 4;
  localparam int PRINT_CAP       = 50;
  localparam int DIRECTED_ROWS   = 24;

  typedef struct packed {
    logic [SLOT_W-1:0] running;
    logic [SLOT_W-1:0] created;
    logic              status;
    logic [TICK_W-1:0] tick;
  } sched_result_t;

  // One row of the directed table; pinned rows carry a hand-written result
  typedef struct packed {
    logic [2:0]        kind;
    logic [TICK_W-1:0] value;
    logic [7:0]        reps;
    logic              pinned;
    sched_result_t     result;
  } request_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [2:0]        kind;
  logic [TICK_W-1:0] value;
  logic              done;
  logic [SLOT_W-1:0] running_task;
  logic [SLOT_W-1:0] new_task;
  logic              status;
  logic [TICK_W-1:0] current_tick;

  edf_task_scheduler DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .value        (value),
    .done         (done),
    .running_task (running_task),
    .new_task     (new_task),
    .status       (status),
    .current_tick (current_tick)
  );

  // Predictor copy of the task table
  bit                task_used   [TASK_SLOTS];
  bit                task_asleep [TASK_SLOTS];
  logic [TICK_W-1:0] task_dl     [TASK_SLOTS];
  logic [TICK_W-1:0] task_wake   [TASK_SLOTS];
  logic [TICK_W-1:0] tick_now;
  int                running_slot;

  sched_result_t pending_results [$];
  int            mismatch_count;
  bit            smooth_run;
  request_row_t  directed_rows [DIRECTED_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t: %s mismatch: got %h expected %h", $time, field, got, want);
  endtask

  // EDF predictor: applies one request and returns the result it should give
  function automatic sched_result_t schedule_request(input logic [2:0] k,
                                                     input logic [TICK_W-1:0] v);
    sched_result_t res;
    int            cur;
    int            best;
    bit            found;
    res = '0;
    cur = running_slot;
    case (k)
      KIND_CREATE: begin
        res.status = STATUS_FAIL;
        for (int i = 1; i < TASK_SLOTS; i++) begin
          if (!task_used[i] && res.status == STATUS_FAIL) begin
            task_used[i]   = 1'b1;
            task_asleep[i] = 1'b0;
            task_dl[i]     = v;
            res.created    = SLOT_W'(i);
            res.status     = STATUS_OK;
          end
        end
      end
      KIND_TERMINATE: begin
        if (cur == 0) begin
          res.status = STATUS_FAIL;
        end else begin
          task_used[cur]   = 1'b0;
          task_asleep[cur] = 1'b0;
        end
      end
      KIND_SLEEP: begin
        if (cur == 0) begin
          res.status = STATUS_FAIL;
        end else begin
          task_wake[cur]   = tick_now + v;
          task_asleep[cur] = 1'b1;
        end
      end
      KIND_SET_DL: begin
        if (cur == 0) res.status = STATUS_FAIL;
        else task_dl[cur] = v;
      end
      KIND_TICK: begin
        tick_now = tick_now + TICK_W'(1);
        for (int i = 0; i < TASK_SLOTS; i++)
          if (task_used[i] && task_asleep[i] &&
              (task_wake[i] == tick_now || task_dl[i] < tick_now))
            task_asleep[i] = 1'b0;
      end
      KIND_SET_TICKS: tick_now = v;
      default: ;
    endcase
    // earliest deadline among ready slots, lowest slot on a tie
    best  = 0;
    found = 1'b0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (task_used[i] && !task_asleep[i] && (!found || task_dl[i] < task_dl[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    running_slot = best;
    res.running  = SLOT_W'(best);
    res.tick     = tick_now;
    return res;
  endfunction

  // Drive one request and hold it until the block takes it
  task automatic issue_request(input logic [2:0] k, input logic [TICK_W-1:0] v,
                               input logic pinned, input sched_result_t pinned_result);
    sched_result_t predicted;
    @(negedge clk);
    start <= 1'b1;
    kind  <= k;
    value <= v;
    do @(posedge clk); while (busy);
    predicted = schedule_request(k, v);
    pending_results.push_back(pinned ? pinned_result : predicted);
  endtask

  // Drop start for a while, or until all results are back
  task automatic pause_sender(input int cycles, input bit drain);
    if (cycles > 0 || drain) begin
      @(negedge clk);
      start <= 1'b0;
      if (drain) wait (pending_results.size() == 0);
      else repeat (cycles - 1) @(posedge clk);
    end
  endtask

  // Mostly back-to-back, some short gaps, a few longer than one request
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (smooth_run || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 45);
  endfunction

  // Result checker: done is a one-cycle strobe that cannot be held off
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", {28'd0, running_task}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (running_task !== want.running)
          flag_mismatch("running_task", {28'd0, running_task}, {28'd0, want.running});
        if (new_task !== want.created)
          flag_mismatch("new_task", {28'd0, new_task}, {28'd0, want.created});
        if (status !== want.status)
          flag_mismatch("status", {31'd0, status}, {31'd0, want.status});
        if (current_tick !== want.tick)
          flag_mismatch("current_tick", current_tick, want.tick);
      end
    end
  end

  initial begin
    int            issued;
    int            r;
    int            n_used;
    int            create_w;
    logic [2:0]    k;
    logic [31:0]   v;

    rst            = 1'b1;
    start          = 1'b0;
    kind           = '0;
    value          = '0;
    mismatch_count = 0;
    smooth_run     = 1'b0;

    // predictor reset: only the idle task, with the largest deadline
    for (int i = 0; i < TASK_SLOTS; i++) begin
      task_used[i]   = 1'b0;
      task_asleep[i] = 1'b0;
      task_dl[i]     = '0;
      task_wake[i]   = '0;
    end
    task_used[0] = 1'b1;
    task_dl[0]   = IDLE_DEADLINE;
    tick_now     = '0;
    running_slot = 0;

    // kind, value, repeat, pinned, {running, new, status, tick}
    directed_rows = '{
      '{KIND_TICK,      32'd0,        8'd1,  1'b1, '{4'd0, 4'd0, STATUS_OK,   32'd1}},
      '{KIND_TERMINATE, 32'hFFFFFFFF, 8'd1,  1'b1, '{4'd0, 4'd0, STATUS_FAIL, 32'd1}},
      '{KIND_SLEEP,     32'd5,        8'd1,  1'b1, '{4'd0, 4'd0, STATUS_FAIL, 32'd1}},
      '{KIND_SET_DL,    32'd0,        8'd1,  1'b1, '{4'd0, 4'd0, STATUS_FAIL, 32'd1}},
      '{KIND_SET_TICKS, 32'hFFFFFFFF, 8'd1,  1'b1, '{4'd0, 4'd0, STATUS_OK,
                                                     32'hFFFFFFFF}},
      '{KIND_TICK,      32'd0,        8'd1,  1'b1, '{4'd0, 4'd0, STATUS_OK,   32'd0}},
      '{KIND_SPARE_A,   32'hFFFFFFFF, 8'd1,  1'b1, '{4'd0, 4'd0, STATUS_OK,   32'd0}},
      '{KIND_SPARE_B,   32'd0,        8'd1,  1'b1, '{4'd0, 4'd0, STATUS_OK,   32'd0}},
      '{KIND_CREATE,    32'hFFFFFFFF, 8'd1,  1'b1, '{4'd0, 4'd1, STATUS_OK,   32'd0}},
      '{KIND_CREATE,    32'd0,        8'd1,  1'b1, '{4'd2, 4'd2, STATUS_OK,   32'd0}},
      '{KIND_SET_DL,    32'hFFFFFFFF, 8'd1,  1'b1, '{4'd0, 4'd0, STATUS_OK,   32'd0}},
      '{KIND_CREATE,    32'd10,       8'd1,  1'b1, '{4'd3, 4'd3, STATUS_OK,   32'd0}},
      // wake by deadline passing, then by wake time matching
      '{KIND_SLEEP,     32'd0,        8'd1,  1'b0, '0},
      '{KIND_TICK,      32'd0,        8'd1,  1'b0, '0},
      '{KIND_SET_TICKS, 32'd10,       8'd1,  1'b0, '0},
      '{KIND_TICK,      32'd0,        8'd1,  1'b0, '0},
      '{KIND_SET_DL,    32'd1000,     8'd1,  1'b0, '0},
      '{KIND_SLEEP,     32'd2,        8'd1,  1'b0, '0},
      '{KIND_TICK,      32'd0,        8'd1,  1'b0, '0},
      '{KIND_TICK,      32'd0,        8'd1,  1'b0, '0},
      '{KIND_TERMINATE, 32'd0,        8'd1,  1'b0, '0},
      // fill the table, then one create too many
      '{KIND_CREATE,    32'h80000000, 8'd13, 1'b0, '0},
      '{KIND_CREATE,    32'd5,        8'd1,  1'b1, '{4'd3, 4'd0, STATUS_FAIL, 32'd13}},
      '{KIND_TERMINATE, 32'd0,        8'd1,  1'b0, '0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      repeat (directed_rows[row].reps) begin
        issue_request(directed_rows[row].kind, directed_rows[row].value,
                      directed_rows[row].pinned, directed_rows[row].result);
        pause_sender(draw_gap(), 1'b0);
      end
    end
    pause_sender(0, 1'b1);

    // random requests; ignored kinds are sent but not counted
    issued = 0;
    while (issued < RANDOM_REQUESTS) begin
      if (issued % 64 == 0) smooth_run = ($urandom_range(0, 3) == 0);
      n_used = 0;
      for (int i = 0; i < TASK_SLOTS; i++) n_used += task_used[i];
      create_w = (n_used >= 12) ? 8 : 24;
      r = $urandom_range(0, 99);
      if (r < create_w) k = KIND_CREATE;
      else if (r < create_w + 12) k = KIND_TERMINATE;
      else if (r < create_w + 28) k = KIND_SLEEP;
      else if (r < create_w + 40) k = KIND_SET_DL;
      else if (r < create_w + 70) k = KIND_TICK;
      else if (r < create_w + 75) k = KIND_SET_TICKS;
      else if (r < create_w + 82) k = KIND_TICK;
      else k = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;

      r = $urandom_range(0, 99);
      v = $urandom;
      case (k)
        // deadlines mostly close to the counter so they expire and tie
        KIND_CREATE, KIND_SET_DL: begin
          if (r < 50) v = tick_now + $urandom_range(0, 40);
          else if (r < 75) v = tick_now + $urandom_range(0, 1000);
          else if (r < 80) v = 32'd0;
          else if (r < 85) v = 32'hFFFFFFFF;
        end
        KIND_SLEEP: begin
          if (r < 60) v = $urandom_range(0, 6);
          else if (r < 80) v = $urandom_range(0, 100);
          else if (r < 90) v = 32'hFFFFFFFF - $urandom_range(0, 3);
        end
        KIND_SET_TICKS: begin
          if (r < 30) v = 32'hFFFFFFFF - $urandom_range(0, 4);
          else if (r < 60) v = $urandom_range(0, 50);
        end
        default: ;
      endcase

      issue_request(k, v, 1'b0, '0);
      if (k != KIND_SPARE_A && k != KIND_SPARE_B) issued++;
      pause_sender(draw_gap(), (issued % 150 == 149));
    end

    // drain and let the block settle
    pause_sender(0, 1'b1);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/edf_pkg.sv
rtl/edf_cell.sv
rtl/edf_task_scheduler.sv
sim/tb_edf_task_scheduler.sv
